// ----- design/page_mapped_ftl_greedy_gc_core_macros.svh -----
// assertion helpers, clocked on clk with asynchronous reset arst_n
`ifndef PAGE_MAPPED_FTL_GREEDY_GC_CORE_MACROS_SVH
`define PAGE_MAPPED_FTL_GREEDY_GC_CORE_MACROS_SVH

`define PMFTL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

`define PMFTL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- design/pmftl_pkg.sv -----
`default_nettype none
package pmftl_pkg;
	localparam int NUM_BLOCKS_DEF        = 64;
	localparam int BLOCK_PAGES_DEF       = 64;
	localparam int MAX_LOGICAL_PAGES_DEF = 4096;

	localparam int LPIU_W   = 13;
	localparam int THR_W    = 6;
	localparam int MODE_W   = 2;
	localparam int LPN_W    = 12;
	localparam int STATUS_W = 2;
	localparam int PHYS_W   = 6;
	localparam int MOVED_W  = 12;
	localparam int ERASED_W = 6;

	localparam logic [LPIU_W-1:0] LPIU_RST = 13'd3584;
	localparam logic [THR_W-1:0]  THR_RST  = 6'd2;

	localparam logic CFG_LPIU = 1'b0;
	localparam logic CFG_THR  = 1'b1;

	localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TRIM  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_NOP   = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	localparam logic [1:0] PG_FREE    = 2'd0;
	localparam logic [1:0] PG_VALID   = 2'd1;
	localparam logic [1:0] PG_INVALID = 2'd2;
endpackage
`default_nettype wire

// ----- design/pmftl_free_fifo.sv -----
`default_nettype none
module pmftl_free_fifo #(
	parameter int NUM_BLOCKS = pmftl_pkg::NUM_BLOCKS_DEF,
	localparam int BW = $clog2(NUM_BLOCKS),
	localparam int CW = $clog2(NUM_BLOCKS + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          init_en,
	input  logic [BW-1:0] init_idx,
	input  logic          push,
	input  logic [BW-1:0] push_blk,
	input  logic          pop,
	output logic [BW-1:0] pop_blk,
	output logic [CW-1:0] count
);
	`include "page_mapped_ftl_greedy_gc_core_macros.svh"

	logic [BW-1:0] mem [NUM_BLOCKS];
	logic [BW-1:0] head_q;
	logic [CW-1:0] cnt_q;
	logic [BW-1:0] rd_q;
	logic [BW:0]   tail_sum;
	logic [BW-1:0] tail;

	assign tail_sum = (BW+1)'(head_q) + (BW+1)'(cnt_q);
	assign tail = (32'(tail_sum) >= NUM_BLOCKS) ? BW'(32'(tail_sum) - NUM_BLOCKS) : BW'(tail_sum);

	always_ff @(posedge clk) begin
		if (init_en) begin
			mem[init_idx] <= (32'(init_idx) == NUM_BLOCKS - 1) ? '0 : init_idx + BW'(1);
		end else if (push && 32'(cnt_q) < NUM_BLOCKS) begin
			mem[tail] <= push_blk;
		end
		if (pop) begin
			rd_q <= mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			cnt_q  <= CW'(NUM_BLOCKS - 1);
		end else if (pop) begin
			head_q <= (32'(head_q) == NUM_BLOCKS - 1) ? '0 : head_q + BW'(1);
			cnt_q  <= cnt_q - CW'(1);
		end else if (push && 32'(cnt_q) < NUM_BLOCKS) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	assign pop_blk = rd_q;
	assign count   = cnt_q;

	`PMFTL_ASSERT(a_no_push_pop, !(push && pop), "push and pop in one cycle")
	`PMFTL_ASSERT_IMP(a_pop_nonempty, pop, cnt_q != '0, "pop from empty free list")
	`PMFTL_ASSERT(a_cnt_bound, 32'(cnt_q) <= NUM_BLOCKS, "free count above block count")
endmodule
`default_nettype wire

// ----- design/page_mapped_ftl_greedy_gc_core.sv -----
`default_nettype none
// page-mapped translation core with greedy garbage collection
// command channel: start with mode and logical_page is taken when busy is low
// result channel: done pulses one cycle with status, read_hit, phys_block,
//   phys_page, moved_pages and blocks_erased; the receiver cannot hold it off
// config: cfg_we writes cfg_data to register cfg_index (0 pages in use, 1 gc
//   threshold); the user must write only while the core is idle, which the
//   block itself does not enforce
// commands: out-of-range and unused-mode commands answer straight from idle;
//   reads, trims and writes go through the map lookup first
// collection: each victim pass scans the count table over NUM_BLOCKS blocks,
//   reads the victim's BLOCK_PAGES pages, moves each valid one, erases them all
// reset: a clearing pass over max(MAX_LOGICAL_PAGES, NUM_BLOCKS*BLOCK_PAGES)
//   entries (4096 by default) initializes map, page and count tables and the
//   free list; busy stays high meanwhile, config writes are still taken
// one command is in flight at a time; done may coincide with the next start
module page_mapped_ftl_greedy_gc_core #(
	parameter int NUM_BLOCKS        = pmftl_pkg::NUM_BLOCKS_DEF,
	parameter int BLOCK_PAGES       = pmftl_pkg::BLOCK_PAGES_DEF,
	parameter int MAX_LOGICAL_PAGES = pmftl_pkg::MAX_LOGICAL_PAGES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [pmftl_pkg::LPIU_W-1:0]      cfg_data,
	input  logic                              start,
	output logic                              busy,
	input  logic [pmftl_pkg::MODE_W-1:0]      mode,
	input  logic [pmftl_pkg::LPN_W-1:0]       logical_page,
	output logic                              done,
	output logic [pmftl_pkg::STATUS_W-1:0]    status,
	output logic                              read_hit,
	output logic [pmftl_pkg::PHYS_W-1:0]      phys_block,
	output logic [pmftl_pkg::PHYS_W-1:0]      phys_page,
	output logic [pmftl_pkg::MOVED_W-1:0]     moved_pages,
	output logic [pmftl_pkg::ERASED_W-1:0]    blocks_erased
);
	import pmftl_pkg::*;
	`include "page_mapped_ftl_greedy_gc_core_macros.svh"

	localparam int BW   = $clog2(NUM_BLOCKS);
	localparam int OW   = $clog2(BLOCK_PAGES);
	localparam int OCW  = $clog2(BLOCK_PAGES + 1);
	localparam int CW   = $clog2(NUM_BLOCKS + 1);
	localparam int LW   = $clog2(MAX_LOGICAL_PAGES);
	localparam int NPP  = NUM_BLOCKS * BLOCK_PAGES;
	localparam int PAW  = $clog2(NPP);
	localparam int CLRN = (MAX_LOGICAL_PAGES > NPP) ? MAX_LOGICAL_PAGES : NPP;
	localparam int CLRW = $clog2(CLRN);
	localparam int MEW  = 1 + BW + OW;
	localparam int PEW  = 2 + LW;
	localparam int BEW  = 2 * OCW;

	typedef enum logic [15:0] {
		S_IDLE    = 16'h0001,
		S_CLR     = 16'h0002,
		S_MAP     = 16'h0004,
		S_RD_PG   = 16'h0008,
		S_INV_PG  = 16'h0010,
		S_INV_BC  = 16'h0020,
		S_ALLOC   = 16'h0040,
		S_POP_W   = 16'h0080,
		S_PROG    = 16'h0100,
		S_PROG_BC = 16'h0200,
		S_COL_CHK = 16'h0400,
		S_SCAN    = 16'h0800,
		S_MV_RD   = 16'h1000,
		S_MV_INV  = 16'h2000,
		S_MV_BC   = 16'h4000,
		S_ERASE   = 16'h8000
	} state_t;

	function automatic logic [PAW-1:0] pa_of(input logic [BW-1:0] b, input logic [OW-1:0] o);
		return PAW'(32'(b) * BLOCK_PAGES + 32'(o));
	endfunction

	logic [MEW-1:0] map_mem [MAX_LOGICAL_PAGES];
	logic [PEW-1:0] pg_mem  [NPP];
	logic [BEW-1:0] bc_mem  [NUM_BLOCKS];

	state_t            state_q;
	logic [CLRW-1:0]   clr_q;
	logic [LPIU_W-1:0] lpiu_q;
	logic [THR_W-1:0]  thr_q;
	logic [MODE_W-1:0] mode_q;
	logic [LW-1:0]     lpn_q;
	logic              gc_q;
	logic              col_done_q;
	logic [BW-1:0]     active_q;
	logic [OCW-1:0]    off_q;
	logic [BW-1:0]     prog_blk_q;
	logic [OW-1:0]     prog_off_q;
	logic [BW-1:0]     idx_q;
	logic [OCW-1:0]    max_q;
	logic              found_q;
	logic [BW-1:0]     best_q;
	logic [BW-1:0]     victim_q;
	logic [OW-1:0]     mv_off_q;
	logic [LW-1:0]     mv_lpn_q;
	logic [OW-1:0]     er_off_q;
	logic [MOVED_W-1:0]  moved_q;
	logic [ERASED_W-1:0] erased_q;
	logic                done_q;
	logic [STATUS_W-1:0] status_q;
	logic                hit_q;
	logic [BW-1:0]       pb_q;
	logic [OW-1:0]       pp_q;

	logic [MEW-1:0] map_rd_q;
	logic [PEW-1:0] pg_rd_q;
	logic [BEW-1:0] bc_rd_q;

	logic           map_re;
	logic [LW-1:0]  map_ra;
	logic           map_we;
	logic [LW-1:0]  map_wa;
	logic [MEW-1:0] map_wd;
	logic           pg_re;
	logic [PAW-1:0] pg_ra;
	logic           pg_we;
	logic [PAW-1:0] pg_wa;
	logic [PEW-1:0] pg_wd;
	logic [BW-1:0]  bc_ra;
	logic           bc_we;
	logic [BW-1:0]  bc_wa;
	logic [BEW-1:0] bc_wd;

	logic          fifo_init;
	logic          fifo_push;
	logic          fifo_pop;
	logic [BW-1:0] fifo_blk;
	logic [CW-1:0] fifo_cnt;

	logic           me_valid;
	logic [BW-1:0]  me_blk;
	logic [OW-1:0]  me_off;
	logic [PAW-1:0] old_pa;
	logic [1:0]     pg_state;
	logic [LW-1:0]  pg_owner;
	logic [OCW-1:0] bc_free;
	logic [OCW-1:0] bc_inv;
	logic [LW-1:0]  prog_lpn;
	logic           accept;
	logic           out_range;
	logic           need_gc;
	logic           off_full;
	logic           mv_last;
	logic           er_last;
	logic           scan_last;
	logic           cand;
	logic           n_found;
	logic [BW-1:0]  n_best;
	logic [OCW-1:0] n_max;

	assign me_valid  = map_rd_q[MEW-1];
	assign me_blk    = map_rd_q[BW+OW-1:OW];
	assign me_off    = map_rd_q[OW-1:0];
	assign old_pa    = pa_of(me_blk, me_off);
	assign pg_state  = pg_rd_q[PEW-1:LW];
	assign pg_owner  = pg_rd_q[LW-1:0];
	assign bc_free   = bc_rd_q[BEW-1:OCW];
	assign bc_inv    = bc_rd_q[OCW-1:0];
	assign prog_lpn  = gc_q ? mv_lpn_q : lpn_q;
	assign accept    = start && (state_q == S_IDLE);
	assign out_range = ({1'b0, logical_page} >= lpiu_q) ||
		(32'(logical_page) >= MAX_LOGICAL_PAGES);
	assign off_full  = (32'(off_q) >= BLOCK_PAGES);
	assign need_gc   = !gc_q && !col_done_q && (32'(fifo_cnt) <= 32'(thr_q));
	assign mv_last   = (32'(mv_off_q) == BLOCK_PAGES - 1);
	assign er_last   = (32'(er_off_q) == BLOCK_PAGES - 1);
	assign scan_last = (32'(idx_q) == NUM_BLOCKS - 1);
	assign cand      = (idx_q != active_q) && (32'(bc_free) != BLOCK_PAGES) &&
		(bc_inv > max_q);
	assign n_found   = cand || found_q;
	assign n_best    = cand ? idx_q : best_q;
	assign n_max     = cand ? bc_inv : max_q;

	assign map_re = accept;
	assign map_ra = LW'(logical_page);

	always_comb begin
		map_we    = 1'b0;
		map_wa    = lpn_q;
		map_wd    = '0;
		pg_re     = 1'b0;
		pg_ra     = '0;
		pg_we     = 1'b0;
		pg_wa     = '0;
		pg_wd     = '0;
		bc_ra     = '0;
		bc_we     = 1'b0;
		bc_wa     = '0;
		bc_wd     = '0;
		fifo_init = 1'b0;
		fifo_pop  = 1'b0;
		fifo_push = 1'b0;
		case (state_q)
			S_CLR: begin
				map_we    = (32'(clr_q) < MAX_LOGICAL_PAGES);
				map_wa    = clr_q[LW-1:0];
				pg_we     = (32'(clr_q) < NPP);
				pg_wa     = clr_q[PAW-1:0];
				bc_we     = (32'(clr_q) < NUM_BLOCKS);
				bc_wa     = clr_q[BW-1:0];
				bc_wd     = {OCW'(BLOCK_PAGES), OCW'(0)};
				fifo_init = (32'(clr_q) < NUM_BLOCKS);
			end
			S_MAP: begin
				if (me_valid) begin
					pg_re = 1'b1;
					pg_ra = old_pa;
					if (mode_q != MODE_READ) begin
						map_we = 1'b1;
					end
				end
			end
			S_INV_PG: begin
				bc_ra = me_blk;
				if (pg_state == PG_VALID) begin
					pg_we = 1'b1;
					pg_wa = old_pa;
					pg_wd = {PG_INVALID, pg_owner};
				end
			end
			S_INV_BC: begin
				bc_we = 1'b1;
				bc_wa = me_blk;
				bc_wd = {bc_free, bc_inv + OCW'(1)};
			end
			S_ALLOC: begin
				fifo_pop = (off_full || col_done_q) && !need_gc && (fifo_cnt != '0);
			end
			S_PROG: begin
				pg_we  = 1'b1;
				pg_wa  = pa_of(prog_blk_q, prog_off_q);
				pg_wd  = {PG_VALID, prog_lpn};
				map_we = 1'b1;
				map_wa = prog_lpn;
				map_wd = {1'b1, prog_blk_q, prog_off_q};
				bc_ra  = prog_blk_q;
			end
			S_PROG_BC: begin
				bc_we = 1'b1;
				bc_wa = prog_blk_q;
				bc_wd = {(bc_free != '0) ? bc_free - OCW'(1) : bc_free, bc_inv};
			end
			S_COL_CHK: begin
				bc_ra = '0;
			end
			S_SCAN: begin
				bc_ra = idx_q + BW'(1);
				if (scan_last && n_found) begin
					pg_re = 1'b1;
					pg_ra = pa_of(n_best, '0);
				end
			end
			S_MV_RD: begin
				if (pg_state != PG_VALID && !mv_last) begin
					pg_re = 1'b1;
					pg_ra = pa_of(victim_q, mv_off_q + OW'(1));
				end
			end
			S_MV_INV: begin
				pg_we = 1'b1;
				pg_wa = pa_of(victim_q, mv_off_q);
				pg_wd = {PG_INVALID, mv_lpn_q};
				bc_ra = victim_q;
			end
			S_MV_BC: begin
				bc_we = 1'b1;
				bc_wa = victim_q;
				bc_wd = {bc_free, bc_inv + OCW'(1)};
				if (!mv_last) begin
					pg_re = 1'b1;
					pg_ra = pa_of(victim_q, mv_off_q + OW'(1));
				end
			end
			S_ERASE: begin
				pg_we = 1'b1;
				pg_wa = pa_of(victim_q, er_off_q);
				pg_wd = '0;
				if (er_off_q == '0) begin
					bc_we = 1'b1;
					bc_wa = victim_q;
					bc_wd = {OCW'(BLOCK_PAGES), OCW'(0)};
				end
				fifo_push = er_last;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_wa] <= map_wd;
		end
		if (map_re) begin
			map_rd_q <= map_mem[map_ra];
		end
		if (pg_we) begin
			pg_mem[pg_wa] <= pg_wd;
		end
		if (pg_re) begin
			pg_rd_q <= pg_mem[pg_ra];
		end
		if (bc_we) begin
			bc_mem[bc_wa] <= bc_wd;
		end
		bc_rd_q <= bc_mem[bc_ra];
	end

	pmftl_free_fifo #(
		.NUM_BLOCKS(NUM_BLOCKS)
	) u_free_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.init_en  (fifo_init),
		.init_idx (clr_q[BW-1:0]),
		.push     (fifo_push),
		.push_blk (victim_q),
		.pop      (fifo_pop),
		.pop_blk  (fifo_blk),
		.count    (fifo_cnt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lpiu_q <= LPIU_RST;
			thr_q  <= THR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LPIU: lpiu_q <= cfg_data;
				CFG_THR:  thr_q  <= cfg_data[THR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			clr_q      <= '0;
			done_q     <= 1'b0;
			gc_q       <= 1'b0;
			col_done_q <= 1'b0;
			active_q   <= '0;
			off_q      <= '0;
			mode_q     <= MODE_NOP;
			lpn_q      <= '0;
			prog_blk_q <= '0;
			prog_off_q <= '0;
			idx_q      <= '0;
			max_q      <= '0;
			found_q    <= 1'b0;
			best_q     <= '0;
			victim_q   <= '0;
			mv_off_q   <= '0;
			mv_lpn_q   <= '0;
			er_off_q   <= '0;
			moved_q    <= '0;
			erased_q   <= '0;
			status_q   <= ST_OK;
			hit_q      <= 1'b0;
			pb_q       <= '0;
			pp_q       <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + CLRW'(1);
					if (32'(clr_q) == CLRN - 1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						mode_q     <= mode;
						lpn_q      <= LW'(logical_page);
						moved_q    <= '0;
						erased_q   <= '0;
						gc_q       <= 1'b0;
						col_done_q <= 1'b0;
						if (mode == MODE_NOP || out_range) begin
							done_q   <= 1'b1;
							status_q <= (mode == MODE_NOP) ? ST_OK : ST_RANGE;
							hit_q    <= 1'b0;
							pb_q     <= '0;
							pp_q     <= '0;
						end else begin
							state_q <= S_MAP;
						end
					end
				end
				S_MAP: begin
					if (me_valid) begin
						state_q <= (mode_q == MODE_READ) ? S_RD_PG : S_INV_PG;
					end else if (mode_q == MODE_WRITE) begin
						state_q <= S_ALLOC;
					end else begin
						done_q   <= 1'b1;
						status_q <= ST_OK;
						hit_q    <= 1'b0;
						pb_q     <= '0;
						pp_q     <= '0;
						state_q  <= S_IDLE;
					end
				end
				S_RD_PG: begin
					done_q   <= 1'b1;
					status_q <= ST_OK;
					hit_q    <= (pg_state == PG_VALID);
					pb_q     <= (pg_state == PG_VALID) ? me_blk : '0;
					pp_q     <= (pg_state == PG_VALID) ? me_off : '0;
					state_q  <= S_IDLE;
				end
				S_INV_PG: begin
					if (pg_state == PG_VALID) begin
						state_q <= S_INV_BC;
					end else if (mode_q == MODE_WRITE) begin
						state_q <= S_ALLOC;
					end else begin
						done_q   <= 1'b1;
						status_q <= ST_OK;
						hit_q    <= 1'b0;
						pb_q     <= '0;
						pp_q     <= '0;
						state_q  <= S_IDLE;
					end
				end
				S_INV_BC: begin
					if (mode_q == MODE_WRITE) begin
						state_q <= S_ALLOC;
					end else begin
						done_q   <= 1'b1;
						status_q <= ST_OK;
						hit_q    <= 1'b0;
						pb_q     <= '0;
						pp_q     <= '0;
						state_q  <= S_IDLE;
					end
				end
				S_ALLOC: begin
					if (!off_full && !col_done_q) begin
						prog_blk_q <= active_q;
						prog_off_q <= off_q[OW-1:0];
						off_q      <= off_q + OCW'(1);
						state_q    <= S_PROG;
					end else if (need_gc) begin
						state_q <= S_COL_CHK;
					end else if (fifo_cnt != '0) begin
						state_q <= S_POP_W;
					end else if (gc_q) begin
						gc_q       <= 1'b0;
						col_done_q <= 1'b1;
					end else begin
						done_q   <= 1'b1;
						status_q <= ST_FULL;
						hit_q    <= 1'b0;
						pb_q     <= '0;
						pp_q     <= '0;
						state_q  <= S_IDLE;
					end
				end
				S_POP_W: begin
					active_q   <= fifo_blk;
					off_q      <= OCW'(1);
					prog_blk_q <= fifo_blk;
					prog_off_q <= '0;
					state_q    <= S_PROG;
				end
				S_PROG: begin
					state_q <= S_PROG_BC;
				end
				S_PROG_BC: begin
					if (gc_q) begin
						state_q <= S_MV_INV;
					end else begin
						done_q   <= 1'b1;
						status_q <= ST_OK;
						hit_q    <= 1'b0;
						pb_q     <= prog_blk_q;
						pp_q     <= prog_off_q;
						state_q  <= S_IDLE;
					end
				end
				S_COL_CHK: begin
					if (32'(fifo_cnt) < 32'(thr_q) + 2) begin
						idx_q   <= '0;
						max_q   <= '0;
						found_q <= 1'b0;
						best_q  <= '0;
						state_q <= S_SCAN;
					end else begin
						col_done_q <= 1'b1;
						state_q    <= S_ALLOC;
					end
				end
				S_SCAN: begin
					max_q   <= n_max;
					found_q <= n_found;
					best_q  <= n_best;
					if (scan_last) begin
						if (n_found) begin
							victim_q <= n_best;
							mv_off_q <= '0;
							state_q  <= S_MV_RD;
						end else begin
							col_done_q <= 1'b1;
							state_q    <= S_ALLOC;
						end
					end else begin
						idx_q <= idx_q + BW'(1);
					end
				end
				S_MV_RD: begin
					if (pg_state == PG_VALID) begin
						mv_lpn_q <= pg_owner;
						gc_q     <= 1'b1;
						state_q  <= S_ALLOC;
					end else if (mv_last) begin
						er_off_q <= '0;
						state_q  <= S_ERASE;
					end else begin
						mv_off_q <= mv_off_q + OW'(1);
					end
				end
				S_MV_INV: begin
					state_q <= S_MV_BC;
				end
				S_MV_BC: begin
					gc_q <= 1'b0;
					if (moved_q != '1) begin
						moved_q <= moved_q + MOVED_W'(1);
					end
					if (mv_last) begin
						er_off_q <= '0;
						state_q  <= S_ERASE;
					end else begin
						mv_off_q <= mv_off_q + OW'(1);
						state_q  <= S_MV_RD;
					end
				end
				S_ERASE: begin
					er_off_q <= er_off_q + OW'(1);
					if (er_last) begin
						if (erased_q != '1) begin
							erased_q <= erased_q + ERASED_W'(1);
						end
						state_q <= S_COL_CHK;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign status        = status_q;
	assign read_hit      = hit_q;
	assign phys_block    = PHYS_W'(pb_q);
	assign phys_page     = PHYS_W'(pp_q);
	assign moved_pages   = moved_q;
	assign blocks_erased = erased_q;

	`PMFTL_ASSERT(a_state_onehot, $onehot(state_q), "state register not one-hot")
	`PMFTL_ASSERT_IMP(a_done_idle, done_q, state_q == S_IDLE, "result strobe while busy")
	`PMFTL_ASSERT(a_off_bound, 32'(off_q) <= BLOCK_PAGES, "append offset past block end")
	`PMFTL_ASSERT_IMP(a_move_no_gc_scan, gc_q, !(state_q == S_SCAN || state_q == S_COL_CHK),
		"victim scan during page move")
endmodule
`default_nettype wire
